// ===== design/tlfq_pkg.sv =====
// Shared types and constants for the three-level feedback queue scheduler.
// Item structs, event and level codes, register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlfq_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int IdWidthDefault    = 8;

  localparam int TaskIdWidth   = 8;
  localparam int DurationWidth = 7;
  localparam int SizeWidth     = 5;
  localparam int CfgIndexWidth = 1;

  localparam logic OpInsert = 1'b0;
  localparam logic OpServe  = 1'b1;

  localparam logic [1:0] LevelFirst  = 2'd0;
  localparam logic [1:0] LevelSecond = 2'd1;
  localparam logic [1:0] LevelThird  = 2'd2;
  localparam logic [1:0] LevelNone   = 2'd3;

  localparam logic CoinToFirst = 1'b0;

  localparam logic [2:0] EvInserted = 3'd0;
  localparam logic [2:0] EvFinished = 3'd1;
  localparam logic [2:0] EvMoved    = 3'd2;
  localparam logic [2:0] EvEmpty    = 3'd3;
  localparam logic [2:0] EvFull     = 3'd4;

  localparam logic [CfgIndexWidth-1:0] CfgQuantumFirst  = 1'd0;
  localparam logic [CfgIndexWidth-1:0] CfgQuantumSecond = 1'd1;

  localparam logic [DurationWidth-1:0] QuantumFirstReset  = 7'd8;
  localparam logic [DurationWidth-1:0] QuantumSecondReset = 7'd16;

  typedef struct packed {
    logic                     op;
    logic [1:0]               queue_select;
    logic                     route_coin;
    logic [TaskIdWidth-1:0]   task_id;
    logic [DurationWidth-1:0] duration;
  } req_item_t;

  typedef struct packed {
    logic [2:0]               event_res;
    logic [TaskIdWidth-1:0]   out_task_id;
    logic [DurationWidth-1:0] run_time;
    logic [DurationWidth-1:0] remaining;
    logic [1:0]               from_level;
    logic [1:0]               to_level;
    logic [SizeWidth-1:0]     size_first;
    logic [SizeWidth-1:0]     size_second;
    logic [SizeWidth-1:0]     size_third;
  } rsp_item_t;

endpackage

`default_nettype wire

// ===== design/tlfq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for each level store of the scheduler. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tlfq_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/three_level_feedback_queue_scheduler_core.sv =====
// Three-level feedback queue scheduler: three task FIFOs held in RAM.
// Depends on tlfq_pkg and tlfq_ram.
//
// An accepted item is held in a request register and executed in the next cycle
// once the result register is free. Inserts and serves of an empty or missing
// level are resolved in S_EXEC; a serve that pops a task also passes through
// S_READ for the registered read of the level store, after which the task is
// finished or written back into its target level if not full. One item is in
// work at a time; a new item is accepted while the previous result still waits
// in the output register. Queue pointers and fill counts live in registers, so
// no clearing pass is needed after reset. Configuration writes are taken at any
// time, with cfg_ready held high.
`timescale 1ns / 1ps
`default_nettype none

module three_level_feedback_queue_scheduler_core #(
  parameter int QUEUE_DEPTH = tlfq_pkg::QueueDepthDefault,
  parameter int ID_WIDTH    = tlfq_pkg::IdWidthDefault
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 req_valid,
  output      logic                                 req_ready,
  input  wire tlfq_pkg::req_item_t                  req_item,
  output      logic                                 rsp_valid,
  input  wire logic                                 rsp_ready,
  output      tlfq_pkg::rsp_item_t                  rsp_item,
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [tlfq_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  wire logic [tlfq_pkg::DurationWidth-1:0]   cfg_data
);

  localparam int DurW   = tlfq_pkg::DurationWidth;
  localparam int EntryW = ID_WIDTH + DurW;
  localparam int PtrW   = $clog2(QUEUE_DEPTH);
  localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t              state, state_next;
  tlfq_pkg::req_item_t req;
  logic [DurW-1:0]     quantum_first, quantum_second;

  logic [PtrW-1:0] head [3];
  logic [PtrW-1:0] tail [3];
  logic [CntW-1:0] count [3];
  logic [PtrW-1:0] head_next [3];
  logic [PtrW-1:0] tail_next [3];
  logic [CntW-1:0] count_next [3];

  logic [2:0]        ram_wr_en, ram_rd_en;
  logic [PtrW-1:0]   ram_wr_addr, ram_rd_addr;
  logic [EntryW-1:0] ram_wr_data;
  logic [EntryW-1:0] ram_rd_data [3];

  tlfq_pkg::rsp_item_t rsp_next;
  logic                rsp_load;
  logic                slot_free;

  logic [EntryW-1:0] pop_entry;
  logic [DurW-1:0]   pop_dur;
  logic [ID_WIDTH-1:0] pop_id;
  logic [DurW-1:0]   quantum;
  logic [DurW-1:0]   left;
  logic [1:0]        to_lvl;

  for (genvar g = 0; g < 3; g++) begin : g_level
    tlfq_ram #(
      .WIDTH (EntryW),
      .DEPTH (QUEUE_DEPTH)
    ) u_store (
      .clk     (clk),
      .wr_en   (ram_wr_en[g]),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en[g]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data[g])
    );
  end

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    case (req.queue_select)
      tlfq_pkg::LevelFirst:  pop_entry = ram_rd_data[0];
      tlfq_pkg::LevelSecond: pop_entry = ram_rd_data[1];
      default:               pop_entry = ram_rd_data[2];
    endcase
    pop_dur = pop_entry[DurW-1:0];
    pop_id  = pop_entry[EntryW-1:DurW];
    quantum = (req.queue_select == tlfq_pkg::LevelFirst) ? quantum_first : quantum_second;
    left    = pop_dur - quantum;
    if (req.queue_select == tlfq_pkg::LevelFirst) begin
      to_lvl = tlfq_pkg::LevelSecond;
    end else if (req.route_coin == tlfq_pkg::CoinToFirst) begin
      to_lvl = tlfq_pkg::LevelFirst;
    end else begin
      to_lvl = tlfq_pkg::LevelThird;
    end
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    ram_wr_en   = '0;
    ram_rd_en   = '0;
    ram_wr_addr = tail[0];
    ram_wr_data = {ID_WIDTH'(req.task_id), req.duration};
    ram_rd_addr = head[0];
    rsp_next    = rsp_item;
    rsp_load    = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          rsp_next            = '0;
          rsp_next.from_level = req.queue_select;
          if (req.op == tlfq_pkg::OpInsert) begin
            rsp_next.from_level  = tlfq_pkg::LevelFirst;
            rsp_next.out_task_id = tlfq_pkg::TaskIdWidth'(ID_WIDTH'(req.task_id));
            rsp_next.remaining   = req.duration;
            if (count[0] == CntFull) begin
              rsp_next.event_res = tlfq_pkg::EvFull;
            end else begin
              rsp_next.event_res = tlfq_pkg::EvInserted;
              ram_wr_en[0]       = 1'b1;
              tail_next[0]       = (tail[0] == PtrLast) ? '0 : tail[0] + 1'b1;
              count_next[0]      = count[0] + 1'b1;
            end
            rsp_load   = 1'b1;
            state_next = S_IDLE;
          end else if (req.queue_select == tlfq_pkg::LevelNone ||
                       count[req.queue_select] == '0) begin
            rsp_next.event_res = tlfq_pkg::EvEmpty;
            rsp_load           = 1'b1;
            state_next         = S_IDLE;
          end else begin
            ram_rd_en[req.queue_select]  = 1'b1;
            ram_rd_addr                  = head[req.queue_select];
            head_next[req.queue_select]  = (head[req.queue_select] == PtrLast) ?
                                           '0 : head[req.queue_select] + 1'b1;
            count_next[req.queue_select] = count[req.queue_select] - 1'b1;
            state_next                   = S_READ;
          end
        end
      end
      S_READ: begin
        rsp_next             = '0;
        rsp_next.from_level  = req.queue_select;
        rsp_next.out_task_id = tlfq_pkg::TaskIdWidth'(pop_id);
        if (req.queue_select == tlfq_pkg::LevelThird || pop_dur <= quantum) begin
          rsp_next.event_res = tlfq_pkg::EvFinished;
          rsp_next.run_time  = pop_dur;
        end else begin
          rsp_next.run_time  = quantum;
          rsp_next.remaining = left;
          rsp_next.to_level  = to_lvl;
          if (count[to_lvl] == CntFull) begin
            rsp_next.event_res = tlfq_pkg::EvFull;
          end else begin
            rsp_next.event_res = tlfq_pkg::EvMoved;
            ram_wr_en[to_lvl]  = 1'b1;
            ram_wr_addr        = tail[to_lvl];
            ram_wr_data        = {pop_id, left};
            tail_next[to_lvl]  = (tail[to_lvl] == PtrLast) ? '0 : tail[to_lvl] + 1'b1;
            count_next[to_lvl] = count[to_lvl] + 1'b1;
          end
        end
        rsp_load   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    rsp_next.size_first  = tlfq_pkg::SizeWidth'(count_next[0]);
    rsp_next.size_second = tlfq_pkg::SizeWidth'(count_next[1]);
    rsp_next.size_third  = tlfq_pkg::SizeWidth'(count_next[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rsp_valid      <= 1'b0;
      quantum_first  <= tlfq_pkg::QuantumFirstReset;
      quantum_second <= tlfq_pkg::QuantumSecondReset;
      for (int i = 0; i < 3; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_index == tlfq_pkg::CfgQuantumFirst) begin
        quantum_first <= cfg_data;
      end
      if (cfg_valid && cfg_index == tlfq_pkg::CfgQuantumSecond) begin
        quantum_second <= cfg_data;
      end
    end
    if (req_valid && req_ready) begin
      req <= req_item;
    end
    if (rsp_load) begin
      rsp_item <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/tlfq_checker.sv =====
// Port-level assertions for the three-level feedback queue scheduler, and the
// bind that attaches them to the top level. Depends on tlfq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlfq_checker #(
  parameter int QUEUE_DEPTH = tlfq_pkg::QueueDepthDefault
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_ready,
  input wire tlfq_pkg::rsp_item_t                rsp_item
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("result item changed while stalled");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp_item.size_first) <= QUEUE_DEPTH &&
                  32'(rsp_item.size_second) <= QUEUE_DEPTH &&
                  32'(rsp_item.size_third) <= QUEUE_DEPTH)
    else $error("queue size above depth");

  a_insert_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.event_res == tlfq_pkg::EvInserted |->
      rsp_item.run_time == '0 && rsp_item.from_level == tlfq_pkg::LevelFirst &&
      rsp_item.to_level == tlfq_pkg::LevelFirst)
    else $error("insert item with bad fields");

  a_finish_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.event_res == tlfq_pkg::EvFinished |->
      rsp_item.remaining == '0 && rsp_item.to_level == tlfq_pkg::LevelFirst &&
      rsp_item.from_level != tlfq_pkg::LevelNone)
    else $error("finished item with bad fields");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.event_res == tlfq_pkg::EvEmpty |->
      rsp_item.out_task_id == '0 && rsp_item.run_time == '0 &&
      rsp_item.remaining == '0)
    else $error("empty item with bad fields");

endmodule

bind three_level_feedback_queue_scheduler_core tlfq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tlfq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_item  (rsp_item)
);

`default_nettype wire

// ===== verif/tb_three_level_feedback_queue_scheduler_core.sv =====
// Testbench for three_level_feedback_queue_scheduler_core: directed, overflow and random traffic.
// A built-in scheduler predictor checks every result. Depends on tlfq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_three_level_feedback_queue_scheduler_core;
  import tlfq_pkg::*;

  localparam int LevelDepth = QueueDepthDefault;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_item_t req_item = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_item_t rsp_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [DurationWidth-1:0] cfg_data = '0;

  three_level_feedback_queue_scheduler_core DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_item(req_item),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_item(rsp_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scheduler state as predicted from accepted items
  logic [TaskIdWidth-1:0] lvl_id [3][LevelDepth];
  logic [DurationWidth-1:0] lvl_dur [3][LevelDepth];
  int unsigned lvl_head [3] = '{0, 0, 0};
  int unsigned lvl_tail [3] = '{0, 0, 0};
  int unsigned lvl_fill [3] = '{0, 0, 0};
  logic [DurationWidth-1:0] quantum_l1 = QuantumFirstReset;
  logic [DurationWidth-1:0] quantum_l2 = QuantumSecondReset;

  rsp_item_t pending_results[$];
  rsp_item_t want;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int idle_pct = 29;
  int stall_pct = 29;

  function automatic bit push_level(int lvl, logic [TaskIdWidth-1:0] id,
                                    logic [DurationWidth-1:0] dur);
    if (lvl_fill[lvl] >= LevelDepth) return 1'b0;
    lvl_id[lvl][lvl_tail[lvl]] = id;
    lvl_dur[lvl][lvl_tail[lvl]] = dur;
    lvl_tail[lvl] = (lvl_tail[lvl] + 1) % LevelDepth;
    lvl_fill[lvl]++;
    return 1'b1;
  endfunction

  function automatic rsp_item_t schedule_step(req_item_t r);
    rsp_item_t res;
    int src;
    logic [TaskIdWidth-1:0] tid;
    logic [DurationWidth-1:0] tdur;
    logic [DurationWidth-1:0] slice;
    res = '0;
    src = int'(r.queue_select);
    if (r.op == OpInsert) begin
      res.out_task_id = r.task_id;
      res.remaining = r.duration;
      res.from_level = LevelFirst;
      res.to_level = LevelFirst;
      res.event_res = push_level(0, r.task_id, r.duration) ? EvInserted : EvFull;
    end else begin
      res.from_level = r.queue_select;
      if (r.queue_select == LevelNone) begin
        res.event_res = EvEmpty;
      end else if (lvl_fill[src] == 0) begin
        res.event_res = EvEmpty;
      end else begin
        tid = lvl_id[src][lvl_head[src]];
        tdur = lvl_dur[src][lvl_head[src]];
        lvl_head[src] = (lvl_head[src] + 1) % LevelDepth;
        lvl_fill[src]--;
        slice = (r.queue_select == LevelFirst) ? quantum_l1 : quantum_l2;
        res.out_task_id = tid;
        if (r.queue_select == LevelThird || tdur <= slice) begin
          res.event_res = EvFinished;
          res.run_time = tdur;
        end else begin
          res.run_time = slice;
          res.remaining = tdur - slice;
          if (r.queue_select == LevelFirst) begin
            res.to_level = LevelSecond;
          end else begin
            res.to_level = (r.route_coin == CoinToFirst) ? LevelFirst : LevelThird;
          end
          res.event_res = push_level(int'(res.to_level), tid, res.remaining) ? EvMoved : EvFull;
        end
      end
    end
    res.size_first = SizeWidth'(lvl_fill[0]);
    res.size_second = SizeWidth'(lvl_fill[1]);
    res.size_third = SizeWidth'(lvl_fill[2]);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int exp_val);
    $display("%0t: mismatch in %s on result %0d: got %0d, want %0d",
             $realtime, field, results_checked, got, exp_val);
    error_count++;
  endtask

  task automatic compare_result(input rsp_item_t got, input rsp_item_t exp_res);
    if (got.event_res !== exp_res.event_res)
      report_mismatch("event_res", got.event_res, exp_res.event_res);
    if (got.out_task_id !== exp_res.out_task_id)
      report_mismatch("out_task_id", got.out_task_id, exp_res.out_task_id);
    if (got.run_time !== exp_res.run_time)
      report_mismatch("run_time", got.run_time, exp_res.run_time);
    if (got.remaining !== exp_res.remaining)
      report_mismatch("remaining", got.remaining, exp_res.remaining);
    if (got.from_level !== exp_res.from_level)
      report_mismatch("from_level", got.from_level, exp_res.from_level);
    if (got.to_level !== exp_res.to_level)
      report_mismatch("to_level", got.to_level, exp_res.to_level);
    if (got.size_first !== exp_res.size_first)
      report_mismatch("size_first", got.size_first, exp_res.size_first);
    if (got.size_second !== exp_res.size_second)
      report_mismatch("size_second", got.size_second, exp_res.size_second);
    if (got.size_third !== exp_res.size_third)
      report_mismatch("size_third", got.size_third, exp_res.size_third);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, event_res", rsp_item.event_res, -1);
      end else begin
        want = pending_results.pop_front();
        compare_result(rsp_item, want);
      end
      results_checked++;
    end
    rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_request(input req_item_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_results.push_back(schedule_step(item));
    items_sent++;
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [CfgIndexWidth-1:0] idx,
                               input logic [DurationWidth-1:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CfgQuantumFirst) quantum_l1 = value;
    else quantum_l2 = value;
    cfg_writes++;
  endtask

  function automatic req_item_t make_insert(logic [TaskIdWidth-1:0] id,
                                            logic [DurationWidth-1:0] dur);
    req_item_t r;
    r.op = OpInsert;
    r.queue_select = 2'($urandom_range(0, 3));
    r.route_coin = 1'($urandom_range(0, 1));
    r.task_id = id;
    r.duration = dur;
    return r;
  endfunction

  function automatic req_item_t make_serve(logic [1:0] lvl, logic coin);
    req_item_t r;
    r.op = OpServe;
    r.queue_select = lvl;
    r.route_coin = coin;
    r.task_id = TaskIdWidth'($urandom_range(0, 255));
    r.duration = DurationWidth'($urandom_range(0, 127));
    return r;
  endfunction

  function automatic req_item_t random_request(int insert_pct);
    req_item_t r;
    r.op = ($urandom_range(0, 99) < insert_pct) ? OpInsert : OpServe;
    r.queue_select = ($urandom_range(0, 19) == 0) ? LevelNone : 2'($urandom_range(0, 2));
    r.route_coin = 1'($urandom_range(0, 1));
    r.task_id = TaskIdWidth'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) r.duration = DurationWidth'($urandom_range(0, 24));
    else r.duration = DurationWidth'($urandom_range(0, 127));
    return r;
  endfunction

  // Serve until every level is empty: third first, then second toward third, then first
  task automatic empty_levels();
    while (lvl_fill[0] + lvl_fill[1] + lvl_fill[2] != 0) begin
      if (lvl_fill[2] != 0) send_request(make_serve(LevelThird, 1'($urandom_range(0, 1))));
      else if (lvl_fill[1] != 0) send_request(make_serve(LevelSecond, ~CoinToFirst));
      else send_request(make_serve(LevelFirst, 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_directed_basics();
    send_request(make_serve(LevelNone, 1'b0));
    send_request(make_serve(LevelNone, 1'b1));
    send_request(make_serve(LevelFirst, 1'b0));
    send_request(make_serve(LevelSecond, 1'b1));
    send_request(make_serve(LevelThird, 1'b0));
    send_request(make_insert(8'h00, 7'd1));
    send_request(make_insert(8'hFF, 7'd127));
    send_request(make_insert(8'h5A, 7'd0));
    send_request(make_insert(8'hA5, 7'd8));
    send_request(make_insert(8'h3C, 7'd9));
    repeat (5) send_request(make_serve(LevelFirst, 1'b1));
    send_request(make_serve(LevelSecond, CoinToFirst));
    send_request(make_serve(LevelSecond, ~CoinToFirst));
    send_request(make_serve(LevelFirst, 1'b0));
    send_request(make_serve(LevelSecond, ~CoinToFirst));
    send_request(make_serve(LevelThird, 1'b1));
    send_request(make_serve(LevelThird, 1'b0));
  endtask

  task automatic test_queue_overflow();
    repeat (LevelDepth + 1)
      send_request(make_insert(TaskIdWidth'($urandom_range(0, 255)),
                               DurationWidth'($urandom_range(40, 127))));
    repeat (LevelDepth) send_request(make_serve(LevelFirst, 1'($urandom_range(0, 1))));
    send_request(make_insert(TaskIdWidth'($urandom_range(0, 255)), 7'd100));
    send_request(make_serve(LevelFirst, 1'b0));
    repeat (LevelDepth) send_request(make_serve(LevelSecond, ~CoinToFirst));
    send_request(make_insert(TaskIdWidth'($urandom_range(0, 255)), 7'd127));
    send_request(make_serve(LevelFirst, 1'b1));
    send_request(make_serve(LevelSecond, ~CoinToFirst));
    repeat (LevelDepth)
      send_request(make_insert(TaskIdWidth'($urandom_range(0, 255)),
                               DurationWidth'($urandom_range(0, 127))));
    send_request(make_insert(TaskIdWidth'($urandom_range(0, 255)), 7'd120));
    repeat (2) send_request(make_serve(LevelFirst, 1'b0));
    repeat (2)
      send_request(make_insert(TaskIdWidth'($urandom_range(0, 255)),
                               DurationWidth'($urandom_range(60, 127))));
    send_request(make_serve(LevelSecond, CoinToFirst));
    empty_levels();
  endtask

  task automatic test_quantum_settings();
    logic [DurationWidth-1:0] first_q [5];
    logic [DurationWidth-1:0] second_q [5];
    first_q = '{7'd1, 7'd127, 7'd0, 7'd127, DurationWidth'($urandom_range(2, 30))};
    second_q = '{7'd1, 7'd127, 7'd0, 7'd1, DurationWidth'($urandom_range(2, 30))};
    for (int s = 0; s < 5; s++) begin
      write_quantum(CfgQuantumFirst, first_q[s]);
      write_quantum(CfgQuantumSecond, second_q[s]);
      for (int n = 0; n < 140; n++) send_request(random_request((n / 35) % 2 == 0 ? 70 : 35));
      empty_levels();
    end
  endtask

  task automatic test_random_traffic();
    write_quantum(CfgQuantumFirst, DurationWidth'($urandom_range(3, 24)));
    write_quantum(CfgQuantumSecond, DurationWidth'($urandom_range(6, 40)));
    for (int n = 0; n < 520; n++) begin
      if (n == 260) wait_for_results();
      send_request(random_request((n / 50) % 2 == 0 ? 75 : 30));
    end
    empty_levels();
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    stall_pct = 0;
    for (int n = 0; n < 200; n++) send_request(random_request((n / 40) % 2 == 0 ? 70 : 35));
    empty_levels();
    idle_pct = 29;
    stall_pct = 29;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_basics();
    test_queue_overflow();
    test_quantum_settings();
    test_random_traffic();
    test_back_to_back();
    wait_for_results();
    $display("Sent %0d scheduler items and checked %0d results", items_sent, results_checked);
    $display("across %0d quantum writes, including zero and full-scale slices", cfg_writes);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/tlfq_pkg.sv
design/tlfq_ram.sv
design/three_level_feedback_queue_scheduler_core.sv
design/tlfq_checker.sv
verif/tb_three_level_feedback_queue_scheduler_core.sv
